// File: rtl/ekd_pkg.sv
// Package for the escape key sequence decoder.
// Holds widths, result kinds and the table of terminal key sequences.
// No dependencies.
package ekd_pkg;

    localparam int CP_W        = 21;
    localparam int BYTE_W      = 8;
    localparam int MAX_SEQ_LEN = 4;
    localparam int NUM_KEYS    = 22;
    localparam int TABLE_ROWS  = 22;
    localparam int ACTIVE_ROWS = (NUM_KEYS < TABLE_ROWS) ? NUM_KEYS : TABLE_ROWS;
    localparam int SEQ_IDX_W   = $clog2(MAX_SEQ_LEN);
    localparam int SEQ_CNT_W   = $clog2(MAX_SEQ_LEN + 1);
    localparam int KEY_IDX_W   = $clog2(TABLE_ROWS);

    localparam logic [CP_W-1:0] ESC_CODE = CP_W'(27);

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_NAMED = 2'd1,
        KIND_ALT   = 2'd2,
        KIND_FLUSH = 2'd3
    } t_kind;

    typedef logic [BYTE_W-1:0] t_byte;

    localparam logic [SEQ_CNT_W-1:0] KEY_LEN [TABLE_ROWS] = '{
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    localparam t_byte KEY_BYTES [TABLE_ROWS][MAX_SEQ_LEN] = '{
        '{"[", "A", 8'h00, 8'h00},
        '{"[", "B", 8'h00, 8'h00},
        '{"[", "C", 8'h00, 8'h00},
        '{"[", "D", 8'h00, 8'h00},
        '{"[", "1", "~", 8'h00},
        '{"[", "3", "~", 8'h00},
        '{"[", "4", "~", 8'h00},
        '{"[", "5", "~", 8'h00},
        '{"[", "6", "~", 8'h00},
        '{"[", "4", "h", 8'h00},
        '{"O", "P", 8'h00, 8'h00},
        '{"O", "Q", 8'h00, 8'h00},
        '{"O", "R", 8'h00, 8'h00},
        '{"O", "S", 8'h00, 8'h00},
        '{"[", "1", "5", "~"},
        '{"[", "1", "7", "~"},
        '{"[", "1", "8", "~"},
        '{"[", "1", "9", "~"},
        '{"[", "2", "0", "~"},
        '{"[", "2", "1", "~"},
        '{"[", "2", "3", "~"},
        '{"[", "2", "4", "~"}
    };

endpackage

// File: rtl/escape_key_sequence_decoder.sv
// Escape key sequence decoder top level.
// Holds the input register, sequence matcher, state and result buffer.
// Depends on ekd_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one key code point per
//   request on i_code_point. Output channel: o_out_valid / i_out_ready carry
//   one result per request on o_kind, o_value and o_last.
//   A request is registered at acceptance; its results are decoded from the
//   input register and registered into the result buffer that drives the output.
//   A plain key or a named key gives one result; ESC and a partial sequence
//   give none; a failed sequence gives one result per buffered byte (up to
//   four), o_last high on the final one.
//   Throughput: one request per cycle while each gives at most one result and
//   the receiver is ready. A failed sequence of n bytes holds the decode stage
//   while the result buffer drains its n results, one per cycle when not stalled.
//   When the receiver stalls, the result buffer holds its contents, the
//   decode stage waits, and o_in_ready drops once the input register fills.
//   Reset (synchronous, i_rst_n low) empties both registers and leaves the
//   block outside any sequence.
module escape_key_sequence_decoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ekd_pkg::CP_W-1:0]  i_code_point,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_kind,
    output logic [ekd_pkg::CP_W-1:0]  o_value,
    output logic                      o_last
);
    import ekd_pkg::*;

    logic                   r_in_valid;
    logic [CP_W-1:0]        r_cp;
    logic                   r_in_esc;
    logic [SEQ_CNT_W-1:0]   r_seq_len;
    t_byte                  r_seq [MAX_SEQ_LEN];
    logic [SEQ_CNT_W-1:0]   r_out_left;
    logic [SEQ_IDX_W-1:0]   r_out_pos;
    t_kind                  r_kind0;
    logic [CP_W-1:0]        r_val [MAX_SEQ_LEN];

    logic                   out_take;
    logic                   out_free;
    logic                   proc;
    t_byte                  byte_in;
    t_byte                  seq_new [MAX_SEQ_LEN];
    logic [SEQ_CNT_W-1:0]   len_new;
    logic                   found;
    logic                   prefix;
    logic                   row_hit;
    logic [KEY_IDX_W-1:0]   hit_idx;
    logic                   seq_we;
    logic                   n_in_esc;
    logic [SEQ_CNT_W-1:0]   n_seq_len;
    logic [SEQ_CNT_W-1:0]   n_res_cnt;
    t_kind                  n_kind0;
    logic [CP_W-1:0]        n_val [MAX_SEQ_LEN];

    assign o_out_valid = (r_out_left != '0);
    assign out_take    = o_out_valid && i_out_ready;
    assign out_free    = (r_out_left == '0) ||
                         ((r_out_left == SEQ_CNT_W'(1)) && i_out_ready);
    assign proc        = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || proc;

    assign o_kind  = (r_out_pos == '0) ? r_kind0 : KIND_FLUSH;
    assign o_value = r_val[r_out_pos];
    assign o_last  = (r_out_left == SEQ_CNT_W'(1));

    // Append the new byte and compare against every table entry
    always_comb begin
        byte_in = r_cp[BYTE_W-1:0];
        len_new = r_seq_len + SEQ_CNT_W'(1);
        for (int i = 0; i < MAX_SEQ_LEN; i++) begin
            seq_new[i] = (SEQ_CNT_W'(i) == r_seq_len) ? byte_in : r_seq[i];
        end
        found   = 1'b0;
        prefix  = 1'b0;
        hit_idx = '0;
        for (int r = 0; r < ACTIVE_ROWS; r++) begin
            row_hit = 1'b1;
            for (int i = 0; i < MAX_SEQ_LEN; i++) begin
                if ((SEQ_CNT_W'(i) < len_new) && (KEY_BYTES[r][i] != seq_new[i])) begin
                    row_hit = 1'b0;
                end
            end
            if (row_hit && (KEY_LEN[r] == len_new) && !found) begin
                found   = 1'b1;
                hit_idx = KEY_IDX_W'(r);
            end else if (row_hit && (KEY_LEN[r] > len_new)) begin
                prefix = 1'b1;
            end
        end
    end

    // Decide results and next sequence state
    always_comb begin
        seq_we    = 1'b0;
        n_in_esc  = r_in_esc;
        n_seq_len = r_seq_len;
        n_res_cnt = '0;
        n_kind0   = KIND_PLAIN;
        for (int i = 0; i < MAX_SEQ_LEN; i++) begin
            n_val[i] = CP_W'(seq_new[i]);
        end
        if (r_cp == ESC_CODE) begin
            n_in_esc  = 1'b1;
            n_seq_len = '0;
        end else if (!r_in_esc) begin
            n_res_cnt = SEQ_CNT_W'(1);
            n_kind0   = KIND_PLAIN;
            n_val[0]  = r_cp;
        end else begin
            seq_we = 1'b1;
            if (found) begin
                n_in_esc  = 1'b0;
                n_seq_len = '0;
                n_res_cnt = SEQ_CNT_W'(1);
                n_kind0   = KIND_NAMED;
                n_val[0]  = CP_W'(hit_idx);
            end else if (prefix && (len_new < SEQ_CNT_W'(MAX_SEQ_LEN))) begin
                n_seq_len = len_new;
            end else begin
                n_in_esc  = 1'b0;
                n_seq_len = '0;
                n_res_cnt = len_new;
                n_kind0   = KIND_ALT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_esc   <= 1'b0;
            r_seq_len  <= '0;
            r_out_left <= '0;
            r_out_pos  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_in_esc  <= n_in_esc;
                r_seq_len <= n_seq_len;
            end
            if (proc && (n_res_cnt != '0)) begin
                r_out_left <= n_res_cnt;
                r_out_pos  <= '0;
            end else if (out_take) begin
                r_out_left <= r_out_left - SEQ_CNT_W'(1);
                r_out_pos  <= r_out_pos + SEQ_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cp <= i_code_point;
        end
        if (proc && seq_we) begin
            r_seq[r_seq_len[SEQ_IDX_W-1:0]] <= byte_in;
        end
        if (proc && (n_res_cnt != '0)) begin
            r_kind0 <= n_kind0;
            r_val   <= n_val;
        end
    end

    a_seq_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_len < SEQ_CNT_W'(MAX_SEQ_LEN))
        else $error("sequence length reached buffer size");

    a_idle_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_esc |-> (r_seq_len == '0))
        else $error("sequence bytes held outside a sequence");

    a_out_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_left <= SEQ_CNT_W'(MAX_SEQ_LEN))
        else $error("result count exceeds buffer");

    a_burst_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_last) |=> (!o_out_valid || (r_out_pos == '0)))
        else $error("new result burst does not start at slot zero");

endmodule
